/* rtl/kce_pkg.sv */
// Package for the k-means clustering engine: sizes, codes and shared types.
// Used by the top level, the run sequencer and the divider; depends on nothing.
package kce_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int MAX_DIMS     = 128;
    localparam int MAX_CLUSTERS = 16;
    localparam int VALUE_BITS   = 16;

    localparam int PT_BITS   = $clog2(MAX_POINTS);
    localparam int DIM_BITS  = $clog2(MAX_DIMS);
    localparam int CL_BITS   = $clog2(MAX_CLUSTERS);
    localparam int CNT_BITS  = PT_BITS + 1;
    localparam int CTR_BITS  = VALUE_BITS + 8;
    localparam int SUM_BITS  = VALUE_BITS + PT_BITS;
    localparam int DIFF_BITS = CTR_BITS;
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int DIST_BITS = SQ_BITS + DIM_BITS + 1;
    localparam int PADDR_BITS = PT_BITS + DIM_BITS;
    localparam int CADDR_BITS = CL_BITS + DIM_BITS;
    localparam int NUM_BITS  = SUM_BITS + 8 + 1;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_RUN   = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    localparam logic [1:0] REG_CLUSTERS = 2'd0;
    localparam logic [1:0] REG_DIMS     = 2'd1;
    localparam logic [1:0] REG_PASSES   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    // Request from the top level to the run sequencer, and its reply.
    typedef struct packed {
        logic                start;
        logic [CL_BITS:0]    k;
        logic [DIM_BITS:0]   dims;
        logic [7:0]          passes;
        logic [CNT_BITS-1:0] npts;
    } run_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } run_stat_t;

endpackage

/* rtl/kmeans_clustering_engine.sv */
// Top level of the k-means clustering engine: ports, load and read handling.
// Depends on kce_pkg, kce_ram and kce_runner.
//
// Loads and clears return nothing; a read returns its result through the
// centre memory's registered port, then the rd_p1_reg and rd_p2_reg registers.
// A run transfer with at least k points occupies the block, for each pass,
// with assignment of every point against each of the k centres and
// accumulation of every point, then the bit-serial mean divider for each
// centre element, and then returns one result. The point and centre memories
// each have one read port. No clearing pass is needed after reset.
module kmeans_clustering_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // element_value[15:0], cluster_select[19:16],
                                   // dim_select[26:20], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // centre_value[23:0], status[25:24],
                                   // point_total[36:26], zero fill
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int DB = kce_pkg::DIM_BITS;
    localparam int NB = kce_pkg::CNT_BITS;

    logic [4:0]    nclu_reg;
    logic [7:0]    ndim_reg;
    logic [7:0]    npass_reg;
    logic [NB-1:0] pts_reg;
    logic [DB-1:0] eptr_reg;
    logic          ovf_reg;
    logic          busy_reg;
    logic          rd_p1_reg, rd_p2_reg;
    logic          rd_ok1_reg;
    logic          ovalid_reg;
    logic [23:0]   oval_reg;
    logic [1:0]    ost_reg;
    logic [NB-1:0] opts_reg;

    logic [kce_pkg::CL_BITS:0] k_eff;
    logic [DB:0]   d_eff;
    logic          acc;
    logic [1:0]    kind;
    logic [15:0]   elem;
    logic [3:0]    csel;
    logic [6:0]    dsel;
    logic [1:0]    st_now;

    kce_pkg::run_req_t  req;
    kce_pkg::run_stat_t stat;

    logic [kce_pkg::PADDR_BITS-1:0] pr_addr;
    logic [15:0] pr_data;
    logic        r_cwe;
    logic [kce_pkg::CADDR_BITS-1:0] r_caddr, r_craddr, c_raddr;
    logic [23:0] r_cwdata, c_rdata;
    logic        p_we;

    assign kind = s_tuser;
    assign elem = s_tdata[15:0];
    assign csel = s_tdata[19:16];
    assign dsel = s_tdata[26:20];

    assign k_eff = (nclu_reg == 5'd0) ? 5'd1 : ((nclu_reg > 5'd16) ? 5'd16 : nclu_reg);
    assign d_eff = (ndim_reg == 8'd0) ? 8'd1 : ((ndim_reg > 8'd128) ? 8'd128 : ndim_reg);

    // A result is held until taken; nothing new enters while one is pending.
    assign s_tready = !busy_reg && !rd_p1_reg && !rd_p2_reg && !ovalid_reg;
    assign acc = s_tvalid && s_tready;
    assign p_we = acc && kind == kce_pkg::KIND_LOAD && pts_reg < NB'(kce_pkg::MAX_POINTS);

    assign st_now = (pts_reg < NB'(k_eff)) ? kce_pkg::ST_FEW :
                    (ovf_reg ? kce_pkg::ST_DROPPED : kce_pkg::ST_OK);

    assign req.start  = acc && kind == kce_pkg::KIND_RUN && pts_reg >= NB'(k_eff);
    assign req.k      = k_eff;
    assign req.dims   = d_eff;
    assign req.passes = npass_reg;
    assign req.npts   = pts_reg;

    assign c_raddr = stat.busy ? r_craddr : {csel, dsel};

    kce_ram #(.WIDTH(16), .DEPTH(kce_pkg::MAX_POINTS * kce_pkg::MAX_DIMS)) u_points (
        .clk  (clk),
        .we   (p_we),
        .waddr({pts_reg[NB-2:0], eptr_reg}),
        .wdata(elem),
        .raddr(pr_addr),
        .rdata(pr_data)
    );

    kce_ram #(.WIDTH(24), .DEPTH(kce_pkg::MAX_CLUSTERS * kce_pkg::MAX_DIMS)) u_centres (
        .clk  (clk),
        .we   (r_cwe),
        .waddr(r_caddr),
        .wdata(r_cwdata),
        .raddr(c_raddr),
        .rdata(c_rdata)
    );

    kce_runner u_run (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .stat   (stat),
        .p_raddr(pr_addr),
        .p_rdata(pr_data),
        .c_we   (r_cwe),
        .c_addr (r_caddr),
        .c_wdata(r_cwdata),
        .c_raddr(r_craddr),
        .c_rdata(c_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nclu_reg   <= 5'd8;
            ndim_reg   <= 8'd128;
            npass_reg  <= 8'd10;
            pts_reg    <= '0;
            eptr_reg   <= '0;
            ovf_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            rd_p1_reg  <= 1'b0;
            rd_p2_reg  <= 1'b0;
            rd_ok1_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    kce_pkg::REG_CLUSTERS: nclu_reg  <= cfg_wdata[4:0];
                    kce_pkg::REG_DIMS:     ndim_reg  <= cfg_wdata;
                    kce_pkg::REG_PASSES:   npass_reg <= cfg_wdata;
                    default:               ;
                endcase
            end
            rd_p1_reg <= 1'b0;
            rd_p2_reg <= rd_p1_reg;
            if (ovalid_reg && m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            if (stat.done)
            begin
                busy_reg   <= 1'b0;
                ovalid_reg <= 1'b1;
            end
            if (rd_p2_reg)
            begin
                ovalid_reg <= 1'b1;
            end
            if (acc)
            begin
                case (kind)
                    kce_pkg::KIND_LOAD:
                    begin
                        if (!p_we)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else if ({1'b0, eptr_reg} + 1'b1 >= d_eff)
                        begin
                            eptr_reg <= '0;
                            pts_reg  <= pts_reg + 1'b1;
                        end
                        else
                        begin
                            eptr_reg <= eptr_reg + 1'b1;
                        end
                    end
                    kce_pkg::KIND_CLEAR:
                    begin
                        pts_reg  <= '0;
                        eptr_reg <= '0;
                        ovf_reg  <= 1'b0;
                    end
                    kce_pkg::KIND_RUN:
                    begin
                        if (req.start)
                        begin
                            busy_reg <= 1'b1;
                        end
                        else
                        begin
                            ovalid_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        rd_p1_reg  <= 1'b1;
                        rd_ok1_reg <= ({1'b0, csel} < k_eff) && ({1'b0, dsel} < d_eff);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && kind == kce_pkg::KIND_RUN)
        begin
            oval_reg <= '0;
        end
        // Centre data is on the memory port in the cycle after the read transfer.
        if (rd_p1_reg)
        begin
            oval_reg <= rd_ok1_reg ? c_rdata : 24'd0;
        end
        if (rd_p2_reg || stat.done || (acc && kind == kce_pkg::KIND_RUN))
        begin
            ost_reg  <= st_now;
            opts_reg <= pts_reg;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {3'd0, opts_reg, ost_reg, oval_reg};

endmodule

/* rtl/kce_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/kce_divider.sv */
// Restoring divider, one quotient bit per cycle, for the centre mean.
// Depends on kce_pkg.
module kce_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [kce_pkg::NUM_BITS-1:0]    numer,
    input  logic [kce_pkg::CNT_BITS-1:0]    denom,
    output logic                            done,
    output logic [kce_pkg::CTR_BITS-1:0]    quot
);

    localparam int NB = kce_pkg::NUM_BITS;
    localparam int CB = kce_pkg::CNT_BITS;

    logic [NB-1:0]      q_reg, q_next;
    logic [CB:0]        r_reg, r_next;
    logic [CB-1:0]      d_reg;
    logic [$clog2(NB+1)-1:0] n_reg, n_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CB:0]        trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        n_next    = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            q_next    = numer;
            r_next    = '0;
            n_next    = ($clog2(NB+1))'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg[CB-1:0], q_reg[NB-1]};
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NB-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NB-2:0], 1'b0};
            end
            n_next = n_reg - 1'b1;
            if (n_reg == ($clog2(NB+1))'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            n_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            n_reg    <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= denom;
        end
    end

    assign done = done_reg;
    assign quot = q_reg[kce_pkg::CTR_BITS-1:0];

endmodule

/* rtl/kce_runner.sv */
// Run sequencer: initial centres, assignment by distance and mean update.
// Depends on kce_pkg, kce_ram and kce_divider.
module kce_runner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kce_pkg::run_req_t                 req,
    output kce_pkg::run_stat_t                stat,
    output logic [kce_pkg::PADDR_BITS-1:0]    p_raddr,
    input  logic [kce_pkg::VALUE_BITS-1:0]    p_rdata,
    output logic                              c_we,
    output logic [kce_pkg::CADDR_BITS-1:0]    c_addr,
    output logic [kce_pkg::CTR_BITS-1:0]      c_wdata,
    output logic [kce_pkg::CADDR_BITS-1:0]    c_raddr,
    input  logic [kce_pkg::CTR_BITS-1:0]      c_rdata
);

    localparam int DB = kce_pkg::DIM_BITS;
    localparam int CB = kce_pkg::CL_BITS;
    localparam int PB = kce_pkg::PT_BITS;
    localparam int NB = kce_pkg::CNT_BITS;
    localparam int SB = kce_pkg::SUM_BITS;
    localparam int XB = kce_pkg::DIST_BITS;
    localparam int CADB = kce_pkg::CADDR_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INIT  = 8'b0000_0010,
        S_CLR   = 8'b0000_0100,
        S_DIST  = 8'b0000_1000,
        S_ACC   = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CB:0]    k_reg;
    logic [DB:0]    dims_reg;
    logic [7:0]     pass_reg, pass_next;
    logic [NB-1:0]  npts_reg;
    logic [PB-1:0]  p_reg, p_next;
    logic [CB-1:0]  c_reg, c_next;
    logic [DB:0]    d_reg, d_next;
    logic [CB-1:0]  best_reg, best_next;
    logic [XB-1:0]  bestd_reg, bestd_next;
    logic [XB-1:0]  acc_reg, acc_next;
    logic [kce_pkg::SQ_BITS-1:0] sq_reg;
    logic [kce_pkg::DIFF_BITS-1:0] diff_reg;
    logic           v1_reg, v2_reg, v3_reg;
    logic           last1_reg, last2_reg, last3_reg;
    logic [NB-1:0]  cnt_reg [kce_pkg::MAX_CLUSTERS];
    logic           cnt_clr, cnt_inc;
    logic [DB-1:0]  d_p1_reg;
    logic           dv1_reg, dv2_reg;

    // Sum store: read-modify-write, the write lands in the cycle after the read.
    logic            s_we;
    logic [CADB-1:0] s_waddr, s_raddr;
    logic [SB-1:0]   s_wdata, s_rdata;
    logic            div_start, div_done;
    logic [kce_pkg::CTR_BITS-1:0] div_q;
    logic [kce_pkg::NUM_BITS-1:0] div_num;
    logic [kce_pkg::DIFF_BITS-1:0] pv;
    logic [kce_pkg::DIFF_BITS-1:0] dnow;
    logic [XB-1:0]   acc_sum;
    logic            clr_we;
    logic [DB-1:0]   clr_d;

    kce_ram #(.WIDTH(SB), .DEPTH(kce_pkg::MAX_CLUSTERS * kce_pkg::MAX_DIMS)) u_sum (
        .clk  (clk),
        .we   (s_we),
        .waddr(s_waddr),
        .wdata(s_wdata),
        .raddr(s_raddr),
        .rdata(s_rdata)
    );

    kce_divider u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .numer(div_num),
        .denom(cnt_reg[c_reg]),
        .done (div_done),
        .quot (div_q)
    );

    assign pv   = {p_rdata, 8'd0};
    assign dnow = (pv > c_rdata) ? pv - c_rdata : c_rdata - pv;
    assign acc_sum = acc_reg + XB'(sq_reg);
    assign clr_we = (state_reg == S_CLR);
    assign clr_d  = d_reg[DB-1:0];

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        best_next  = best_reg;
        bestd_next = bestd_reg;
        acc_next   = acc_reg;
        p_raddr    = {p_reg, d_reg[DB-1:0]};
        c_raddr    = {c_reg, d_reg[DB-1:0]};
        c_we       = 1'b0;
        c_addr     = {c_reg, d_p1_reg};
        c_wdata    = {p_rdata, 8'd0};
        s_raddr    = {best_reg, d_reg[DB-1:0]};
        s_we       = 1'b0;
        s_waddr    = {best_reg, d_p1_reg};
        s_wdata    = s_rdata + SB'(p_rdata);
        cnt_clr    = 1'b0;
        cnt_inc    = 1'b0;
        div_start  = 1'b0;
        // Rounded mean: (sum * 256 + count / 2) / count.
        div_num    = {1'b0, s_rdata, 8'd0}
                     + {{(kce_pkg::NUM_BITS-NB+1){1'b0}}, cnt_reg[c_reg][NB-1:1]};
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    state_next = S_INIT;
                    pass_next = req.passes;
                    c_next = '0;
                    d_next = '0;
                    p_next = '0;
                end
            end
            S_INIT:
            begin
                // Copy point c into centre c; reads issue on d, writes land on d_p1.
                p_raddr = {PB'(c_reg), d_reg[DB-1:0]};
                c_we    = dv1_reg;
                if (d_reg < dims_reg)
                begin
                    d_next = d_reg + 1'b1;
                end
                else if (!dv1_reg && !dv2_reg)
                begin
                    d_next = '0;
                    if ({1'b0, c_reg} == k_reg - 1'b1)
                    begin
                        c_next = '0;
                        if (pass_reg == 8'd0)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_CLR;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            S_CLR:
            begin
                s_we    = 1'b1;
                s_waddr = {c_reg, clr_d};
                s_wdata = '0;
                cnt_clr = 1'b1;
                if (d_reg == dims_reg - 1'b1)
                begin
                    d_next = '0;
                    if ({1'b0, c_reg} == k_reg - 1'b1)
                    begin
                        c_next = '0;
                        p_next = '0;
                        acc_next = '0;
                        state_next = S_DIST;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    d_next = d_reg + 1'b1;
                end
            end
            S_DIST:
            begin
                if (d_reg < dims_reg)
                begin
                    d_next = d_reg + 1'b1;
                end
                if (v3_reg)
                begin
                    acc_next = acc_sum;
                end
                if (last3_reg)
                begin
                    acc_next = '0;
                    if (c_reg == '0 || acc_sum < bestd_reg)
                    begin
                        bestd_next = acc_sum;
                        best_next  = c_reg;
                    end
                    d_next = '0;
                    if ({1'b0, c_reg} == k_reg - 1'b1)
                    begin
                        state_next = S_ACC;
                        c_next = '0;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            S_ACC:
            begin
                // Sum read and point read both issue on d and land together.
                s_we = dv1_reg;
                if (d_reg < dims_reg)
                begin
                    d_next = d_reg + 1'b1;
                end
                else if (!dv1_reg && !dv2_reg)
                begin
                    cnt_inc = 1'b1;
                    d_next = '0;
                    if ({1'b0, p_reg} == npts_reg - 1'b1)
                    begin
                        state_next = S_UPD;
                        p_next = '0;
                    end
                    else
                    begin
                        p_next = p_reg + 1'b1;
                        state_next = S_DIST;
                    end
                end
            end
            S_UPD:
            begin
                s_raddr = {c_reg, d_reg[DB-1:0]};
                if (cnt_reg[c_reg] == '0 || d_reg == dims_reg)
                begin
                    d_next = '0;
                    if ({1'b0, c_reg} == k_reg - 1'b1)
                    begin
                        c_next = '0;
                        pass_next = pass_reg - 1'b1;
                        state_next = (pass_reg == 8'd1) ? S_DONE : S_CLR;
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                s_raddr   = {c_reg, d_reg[DB-1:0]};
                div_start = dv1_reg;
                c_addr    = {c_reg, d_reg[DB-1:0]};
                c_wdata   = div_q;
                if (div_done)
                begin
                    c_we = 1'b1;
                    d_next = d_reg + 1'b1;
                    state_next = S_UPD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            last1_reg <= 1'b0;
            last2_reg <= 1'b0;
            last3_reg <= 1'b0;
            dv1_reg   <= 1'b0;
            dv2_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv1_reg   <= ((state_reg == S_INIT || state_reg == S_ACC) && d_reg < dims_reg)
                         || (state_reg == S_UPD && state_next == S_DIV);
            dv2_reg   <= dv1_reg && state_reg != S_DIV;
            v1_reg    <= (state_reg == S_DIST) && d_reg < dims_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            last1_reg <= (state_reg == S_DIST) && d_reg == dims_reg - 1'b1;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pass_reg  <= pass_next;
        p_reg     <= p_next;
        c_reg     <= c_next;
        d_reg     <= d_next;
        best_reg  <= best_next;
        bestd_reg <= bestd_next;
        acc_reg   <= acc_next;
        diff_reg  <= dnow;
        sq_reg    <= diff_reg * diff_reg;
        d_p1_reg  <= d_reg[DB-1:0];
        if (state_reg == S_IDLE && req.start)
        begin
            k_reg    <= req.k;
            dims_reg <= req.dims;
            npts_reg <= req.npts;
        end
        for (int i = 0; i < kce_pkg::MAX_CLUSTERS; i++)
        begin
            if (cnt_clr)
            begin
                cnt_reg[i] <= '0;
            end
            else if (cnt_inc && best_reg == CB'(i))
            begin
                cnt_reg[i] <= cnt_reg[i] + 1'b1;
            end
        end
    end

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);

endmodule

/* rtl/kce_checker.sv */
// Port-level checker for the k-means clustering engine, bound to the top level.
// Depends on kmeans_clustering_engine's ports only.
module kce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[25:24] != 2'd3)
        else $error("bad status code");

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[36:26] <= 11'd1024 && m_tdata[39:37] == 3'd0)
        else $error("point total out of range");

endmodule

bind kmeans_clustering_engine kce_checker u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
